### hdl/pct_pkg.sv
// ----------------------------------------------------------------------------
// pct_pkg: shared types, constants and functions of the convexity test
// Coordinate and edge widths, turn sign codes, and the turn sign logic.
// ----------------------------------------------------------------------------
`default_nettype none

package pct_pkg;

    localparam int COORD_W      = 16;
    localparam int EDGE_W       = COORD_W + 1;
    localparam int PROD_W       = 2 * EDGE_W;
    localparam int SIGN_W       = 2;
    localparam int MIN_VERTICES = 3;

    localparam logic signed [SIGN_W-1:0] SIGN_ZERO = 2'sb00;
    localparam logic signed [SIGN_W-1:0] SIGN_POS  = 2'sb01;
    localparam logic signed [SIGN_W-1:0] SIGN_NEG  = 2'sb11;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [EDGE_W-1:0]  edge_t;
    typedef logic signed [SIGN_W-1:0]  sign_t;

    typedef struct packed {
        sign_t sign;
        logic  not_convex;
    } turn_state_t;

    // Sign of ax*by - ay*bx, taken by comparing the two products.
    function automatic sign_t cross_sign(edge_t ax, edge_t ay, edge_t bx, edge_t by);
        logic signed [PROD_W-1:0] p1;
        logic signed [PROD_W-1:0] p2;
        sign_t                    s;
        p1 = ax * by;
        p2 = ay * bx;
        if (p1 > p2) begin
            s = SIGN_POS;
        end else if (p1 < p2) begin
            s = SIGN_NEG;
        end else begin
            s = SIGN_ZERO;
        end
        return s;
    endfunction

    // Fold one turn into the running orientation: skip zero turns, let the
    // first nonzero turn set the orientation, flag any later disagreement.
    function automatic turn_state_t merge_turn(turn_state_t st, sign_t s);
        turn_state_t r;
        r = st;
        if (s != SIGN_ZERO) begin
            if (st.sign == SIGN_ZERO) begin
                r.sign = s;
            end else if (st.sign != s) begin
                r.not_convex = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic edge_t coord_diff(coord_t to_c, coord_t from_c);
        edge_t t;
        edge_t f;
        t = {to_c[COORD_W-1], to_c};
        f = {from_c[COORD_W-1], from_c};
        return t - f;
    endfunction

endpackage

`default_nettype wire

### hdl/polygon_convexity_test.sv
// Result path: an accepted final vertex goes through the input register, then
// the result register, to m_valid; other vertices produce no result.
// Throughput: one vertex per cycle, a final one only into a free result slot;
// three cross product compares at most lie between input and result register.
// Reset: synchronous, active low aresetn; clears all control state and the
// polygon in progress. After each final vertex the polygon starts over.
// ----------------------------------------------------------------------------
// polygon_convexity_test: convexity test of a closed polygon
// Takes vertices one per cycle (the final one only with a free result slot);
// on it, the common turn sign of all edges (+1/-1), 0 if nonconvex/degenerate.
// ----------------------------------------------------------------------------
`default_nettype none

module polygon_convexity_test (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire pct_pkg::coord_t       s_vertex_x,
    input  wire pct_pkg::coord_t       s_vertex_y,
    input  wire logic                  s_is_last,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output pct_pkg::sign_t             m_orientation
);
    import pct_pkg::*;

    // input register
    logic        in_valid_reg;
    coord_t      in_x_reg;
    coord_t      in_y_reg;
    logic        in_last_reg;

    // polygon state
    coord_t      first_x_reg;
    coord_t      first_y_reg;
    coord_t      prev_x_reg;
    coord_t      prev_y_reg;
    edge_t       first_ex_reg;
    edge_t       first_ey_reg;
    edge_t       prev_ex_reg;
    edge_t       prev_ey_reg;
    logic [1:0]  count_reg;
    turn_state_t turn_reg;
    turn_state_t turn_next;

    // result register
    logic        out_valid_reg;
    sign_t       out_orient_reg;

    logic        out_free;
    logic        advance;
    logic        have_turn;
    edge_t       ex;
    edge_t       ey;
    edge_t       cx;
    edge_t       cy;
    turn_state_t st1;
    turn_state_t st2;
    turn_state_t st3;
    sign_t       result;

    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && (!in_last_reg || out_free);
    assign s_ready  = !in_valid_reg || advance;

    assign m_valid       = out_valid_reg;
    assign m_orientation = out_orient_reg;

    // have_turn: at least two vertices already held, so a previous edge exists
    assign have_turn = count_reg >= 2'(MIN_VERTICES - 1);

    always_comb begin
        ex  = coord_diff(in_x_reg, prev_x_reg);
        ey  = coord_diff(in_y_reg, prev_y_reg);
        cx  = coord_diff(first_x_reg, in_x_reg);
        cy  = coord_diff(first_y_reg, in_y_reg);
        st1 = turn_reg;
        if (have_turn) begin
            st1 = merge_turn(turn_reg, cross_sign(prev_ex_reg, prev_ey_reg, ex, ey));
        end
        // closing edge: turn into it and from it back into the first edge
        st2    = merge_turn(st1, cross_sign(ex, ey, cx, cy));
        st3    = merge_turn(st2, cross_sign(cx, cy, first_ex_reg, first_ey_reg));
        result = SIGN_ZERO;
        if (have_turn && !st3.not_convex) begin
            result = st3.sign;
        end
        turn_next = st1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            in_x_reg    <= s_vertex_x;
            in_y_reg    <= s_vertex_y;
            in_last_reg <= s_is_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            turn_reg  <= '{sign: SIGN_ZERO, not_convex: 1'b0};
        end else if (advance) begin
            if (in_last_reg) begin
                count_reg <= '0;
                turn_reg  <= '{sign: SIGN_ZERO, not_convex: 1'b0};
            end else begin
                if (count_reg != 2'(MIN_VERTICES)) begin
                    count_reg <= count_reg + 2'd1;
                end
                turn_reg <= turn_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && !in_last_reg) begin
            if (count_reg == 2'd0) begin
                first_x_reg <= in_x_reg;
                first_y_reg <= in_y_reg;
            end
            if (count_reg == 2'd1) begin
                first_ex_reg <= ex;
                first_ey_reg <= ey;
            end
            if (count_reg != 2'd0) begin
                prev_ex_reg <= ex;
                prev_ey_reg <= ey;
            end
            prev_x_reg <= in_x_reg;
            prev_y_reg <= in_y_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= advance && in_last_reg;
        end
        if (advance && in_last_reg) begin
            out_orient_reg <= result;
        end
    end

endmodule

`default_nettype wire

### hdl/pct_checker.sv
// ----------------------------------------------------------------------------
// pct_checker: port-level checks of the convexity test
// Watches the top level's ports and is attached to it by a bind statement.
// ----------------------------------------------------------------------------
`default_nettype none

module pct_checker (
    input wire logic           aclk,
    input wire logic           aresetn,
    input wire logic           s_ready,
    input wire logic           m_valid,
    input wire logic           m_ready,
    input wire pct_pkg::sign_t m_orientation
);
    import pct_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_orientation))
        else $error("result changed while stalled");

    // only +1, -1 or 0 leave the block
    a_orient_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_orientation == SIGN_ZERO || m_orientation == SIGN_POS ||
                     m_orientation == SIGN_NEG))
        else $error("orientation code out of range");

    // with the result slot empty, nothing blocks the input
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty result slot");

    // reset drops any pending result
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind polygon_convexity_test pct_checker u_pct_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_orientation (m_orientation)
);

`default_nettype wire
